// ----- design/rrtl_pkg.sv -----
// Package for the round-robin task run list: opcodes, status codes,
// task state codes, controller state type and controller/datapath structs.
// No dependencies.
package rrtl_pkg;

  // Fixed payload widths
  localparam int OPCODE_W = 2;
  localparam int TASK_W   = 4;
  localparam int STATUS_W = 2;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_RUN   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SLEEP = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SLICE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOCHG   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd2;

  // Per-task state codes
  localparam logic [1:0] TS_IDLE  = 2'd0;
  localparam logic [1:0] TS_RUN   = 2'd1;
  localparam logic [1:0] TS_SLEEP = 2'd2;

  // Minimum running tasks for a slice expiry to rotate
  localparam int SLICE_MIN_RUNNING = 2;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch item, read link memories
    logic execute;   // update lists, load result register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

// ----- design/rrtl_if.sv -----
// Handshake interfaces for request items and result items.
// Depends on rrtl_pkg for payload widths.
interface rrtl_req_if;
  logic                           valid;
  logic                           ready;
  logic [rrtl_pkg::OPCODE_W-1:0]  opcode;
  logic [rrtl_pkg::TASK_W-1:0]    task_id;

  modport source (output valid, output opcode, output task_id, input ready);
  modport sink   (input valid, input opcode, input task_id, output ready);
endinterface

interface rrtl_res_if;
  logic                           valid;
  logic                           ready;
  logic                           do_switch;
  logic [rrtl_pkg::TASK_W-1:0]    target_task;
  logic [rrtl_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output do_switch, output target_task, output status,
                  input ready);
  modport sink   (input valid, input do_switch, input target_task, input status,
                  output ready);
endinterface

// ----- design/rrtl_ctrl.sv -----
// Controller for the run list: two-state sequencer that captures an item
// and then commits its update once the result register is free.
// Depends on rrtl_pkg.
module rrtl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  out_ready,
  input  rrtl_pkg::dp_status_t  status,
  output rrtl_pkg::ctl_cmd_t    cmd
);
  import rrtl_pkg::*;

  ctl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // commit only when the result slot is empty or draining
        if (!status.out_full || out_ready) begin
          cmd.execute = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- design/rrtl_dp.sv -----
// Datapath for the run list: task state flops, next/prev link memories,
// head/tail/current/count registers and the result register.
// Depends on rrtl_pkg.
module rrtl_dp #(
  parameter int MAX_TASKS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rrtl_pkg::ctl_cmd_t              cmd,
  output rrtl_pkg::dp_status_t            status,
  input  logic [rrtl_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [rrtl_pkg::TASK_W-1:0]     in_task_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_do_switch,
  output logic [rrtl_pkg::TASK_W-1:0]     out_target_task,
  output logic [rrtl_pkg::STATUS_W-1:0]   out_status
);
  import rrtl_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int XW = IW + TASK_W;

  // Link memories and task states
  logic [IW-1:0] next_mem [MAX_TASKS];
  logic [IW-1:0] prev_mem [MAX_TASKS];
  logic [1:0]    tstate   [MAX_TASKS];

  // List registers
  logic [IW-1:0] head, tail, cur;
  logic [CW-1:0] count;

  // Captured item and registered link reads
  logic [OPCODE_W-1:0] op_q;
  logic [IW-1:0]       t_q;
  logic                t_ok_q;
  logic [IW-1:0]       nxt_rd, prv_rd;

  // Incoming task id widened for range check and index
  logic [XW-1:0] t_wide;
  logic [IW-1:0] t_idx;
  logic          t_ok;
  logic [IW-1:0] rd_addr;

  assign t_wide  = {{IW{1'b0}}, in_task_id};
  assign t_idx   = t_wide[IW-1:0];
  assign t_ok    = (t_wide < XW'(MAX_TASKS));
  assign rd_addr = (in_opcode == OP_SLICE) ? cur : t_idx;

  // Update decisions
  logic [IW-1:0]       head_n, tail_n, cur_n;
  logic [CW-1:0]       count_n;
  logic                sw_n;
  logic [STATUS_W-1:0] st_n;
  logic                ts_we;
  logic [1:0]          ts_wd;
  logic                next_we, prev_we;
  logic [IW-1:0]       next_wa, next_wd, prev_wa, prev_wd;
  logic [1:0]          ts_cur;
  logic                was_cur;

  assign ts_cur  = tstate[t_q];
  assign was_cur = (cur == t_q);

  always_comb begin
    head_n  = head;
    tail_n  = tail;
    cur_n   = cur;
    count_n = count;
    sw_n    = 1'b0;
    st_n    = STAT_NOCHG;
    ts_we   = 1'b0;
    ts_wd   = TS_SLEEP;
    next_we = 1'b0;
    next_wa = tail;
    next_wd = t_q;
    prev_we = 1'b0;
    prev_wa = t_q;
    prev_wd = tail;
    unique case (op_q)
      OP_SLICE: begin
        if (count >= CW'(SLICE_MIN_RUNNING)) begin
          cur_n = (cur == tail) ? head : nxt_rd;
          sw_n  = 1'b1;
          st_n  = STAT_DONE;
        end
      end
      OP_RUN: begin
        // append at the tail
        if (t_ok_q && ts_cur != TS_RUN) begin
          ts_we   = 1'b1;
          ts_wd   = TS_RUN;
          count_n = count + CW'(1);
          next_we = 1'b1;
          prev_we = 1'b1;
          tail_n  = t_q;
          st_n    = STAT_DONE;
        end
      end
      OP_SLEEP: begin
        if (t_ok_q) begin
          if (ts_cur == TS_IDLE) begin
            // not linked: mark only
            ts_we = 1'b1;
            st_n  = STAT_DONE;
          end else if (ts_cur == TS_RUN) begin
            if (count <= CW'(1)) begin
              st_n = STAT_REFUSED;
            end else begin
              count_n = count - CW'(1);
              if (head == t_q) begin
                head_n = nxt_rd;
                if (was_cur) cur_n = nxt_rd;
              end else if (tail == t_q) begin
                tail_n = prv_rd;
                if (was_cur) cur_n = head;
              end else begin
                // unlink from the middle
                next_we = 1'b1;
                next_wa = prv_rd;
                next_wd = nxt_rd;
                prev_we = 1'b1;
                prev_wa = nxt_rd;
                prev_wd = prv_rd;
                if (was_cur) cur_n = nxt_rd;
              end
              ts_we = 1'b1;
              sw_n  = was_cur;
              st_n  = STAT_DONE;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Link memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.execute && next_we) next_mem[next_wa] <= next_wd;
    if (cmd.execute && prev_we) prev_mem[prev_wa] <= prev_wd;
    if (cmd.capture) begin
      nxt_rd <= next_mem[rd_addr];
      prv_rd <= prev_mem[rd_addr];
    end
  end

  // Captured item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= in_opcode;
      t_q    <= t_idx;
      t_ok_q <= t_ok;
    end
  end

  // Task states: task 0 running, others idle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) tstate[i] <= (i == 0) ? TS_RUN : TS_IDLE;
    end else if (cmd.execute && ts_we) begin
      tstate[t_q] <= ts_wd;
    end
  end

  // List registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      cur   <= '0;
      count <= CW'(1);
    end else if (cmd.execute) begin
      head  <= head_n;
      tail  <= tail_n;
      cur   <= cur_n;
      count <= count_n;
    end
  end

  // Result register
  logic [XW-1:0] cur_n_wide;
  assign cur_n_wide = {{TASK_W{1'b0}}, cur_n};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_do_switch   <= sw_n;
      out_target_task <= cur_n_wide[TASK_W-1:0];
      out_status      <= st_n;
    end
  end

  assign status.out_full = out_valid;

  // The last running task can never leave the list
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst) count != '0)
    else $error("running count reached zero");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TASKS))
    else $error("running count above task limit");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_valid)
    else $error("committed item produced no result");

endmodule

// ----- design/round_robin_task_run_list_unit.sv -----
// Top level of the round-robin task run list; ties controller and datapath.
// Depends on rrtl_pkg, rrtl_if, rrtl_ctrl and rrtl_dp.
//
// On accept, a request item reads the next/prev link memories for the
// named task (or the current task on slice expiry); then, in the S_EXEC
// state, the list update is committed and the result register loaded. A new
// item is accepted on the cycle after the commit, not while one is in
// flight; the commit waits while a previous result is still held and not
// taken. Exactly one result item is produced per request. Tasks with ids at
// or above MAX_TASKS, and unused opcodes, return status "no change".
module round_robin_task_run_list_unit #(
  parameter int MAX_TASKS = 16
) (
  input  logic            clk,
  input  logic            rst,
  rrtl_req_if.sink        req,
  rrtl_res_if.source      res
);
  import rrtl_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  rrtl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rrtl_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_opcode       (req.opcode),
    .in_task_id      (req.task_id),
    .out_valid       (res.valid),
    .out_ready       (res.ready),
    .out_do_switch   (res.do_switch),
    .out_target_task (res.target_task),
    .out_status      (res.status)
  );

endmodule

// ----- dv/rrtl_run_list_checker.sv -----
// Checker for the round-robin task run list: watches both channels, keeps its own
// copy of the run list, predicts one result per request item and compares.
// Depends on rrtl_pkg and the rrtl_req_if / rrtl_res_if interfaces.
module rrtl_run_list_checker #(
  parameter int NUM_TASKS = 16
) (
  input  logic clk,
  input  logic rst,
  rrtl_req_if  req,
  rrtl_res_if  res,
  output int   errors,
  output int   outstanding,
  output int   checked
);
  import rrtl_pkg::*;

  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic                do_switch;
    logic [TASK_W-1:0]   target_task;
    logic [STATUS_W-1:0] status;
  } sched_result_t;

  // Shadow run list
  logic [1:0]        task_st [NUM_TASKS];
  logic [TASK_W-1:0] next_l  [NUM_TASKS];
  logic [TASK_W-1:0] prev_l  [NUM_TASKS];
  logic [TASK_W-1:0] head_task, tail_task, cur_task;
  logic [4:0]        n_running;

  sched_result_t pending_results[$];

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("[%0t] mismatch: %s", $time, msg);
    else if (errors == MAX_PRINTED + 1)
      $display("[%0t] further mismatches are counted but not printed", $time);
  endtask

  task automatic clear_run_list();
    for (int i = 0; i < NUM_TASKS; i++) begin
      task_st[i] = TS_IDLE;
      next_l[i]  = '0;
      prev_l[i]  = '0;
    end
    task_st[0] = TS_RUN;
    head_task  = '0;
    tail_task  = '0;
    cur_task   = '0;
    n_running  = 5'd1;
  endtask

  // Apply one request to the shadow list and return the result it gives
  function automatic sched_result_t advance_run_list(input logic [OPCODE_W-1:0] op,
                                                     input logic [TASK_W-1:0] id);
    sched_result_t r;
    logic          was_cur;
    logic [TASK_W-1:0] p, n;
    r.do_switch = 1'b0;
    r.status    = STAT_NOCHG;
    if (op == OP_SLICE) begin
      if (n_running >= SLICE_MIN_RUNNING) begin
        cur_task    = (cur_task == tail_task) ? head_task : next_l[cur_task];
        r.do_switch = 1'b1;
        r.status    = STAT_DONE;
      end
    end else if ((op == OP_RUN || op == OP_SLEEP) && int'(id) < NUM_TASKS) begin
      if (op == OP_RUN) begin
        // append at tail unless already running
        if (task_st[id] != TS_RUN) begin
          task_st[id]       = TS_RUN;
          n_running         = n_running + 5'd1;
          next_l[tail_task] = id;
          prev_l[id]        = tail_task;
          tail_task         = id;
          r.status          = STAT_DONE;
        end
      end else if (task_st[id] == TS_IDLE) begin
        // not linked: only marked asleep
        task_st[id] = TS_SLEEP;
        r.status    = STAT_DONE;
      end else if (task_st[id] == TS_RUN) begin
        if (n_running <= 5'd1) begin
          r.status = STAT_REFUSED;
        end else begin
          was_cur   = (cur_task == id);
          n_running = n_running - 5'd1;
          if (head_task == id) begin
            head_task = next_l[id];
            if (was_cur) cur_task = head_task;
          end else if (tail_task == id) begin
            tail_task = prev_l[id];
            if (was_cur) cur_task = head_task;
          end else begin
            p         = prev_l[id];
            n         = next_l[id];
            next_l[p] = n;
            prev_l[n] = p;
            if (was_cur) cur_task = n;
          end
          task_st[id] = TS_SLEEP;
          r.do_switch = was_cur;
          r.status    = STAT_DONE;
        end
      end
    end
    r.target_task = cur_task;
    return r;
  endfunction

  // Compare accepted results, then predict for accepted requests
  always @(posedge clk) begin
    sched_result_t want;
    if (rst) begin
      clear_run_list();
      pending_results.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result item with none expected (switch %0b task %0d status %0d)",
                           res.do_switch, res.target_task, res.status));
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (res.do_switch !== want.do_switch)
            report($sformatf("do_switch got %0b, expected %0b", res.do_switch, want.do_switch));
          if (res.target_task !== want.target_task)
            report($sformatf("target_task got %0d, expected %0d",
                             res.target_task, want.target_task));
          if (res.status !== want.status)
            report($sformatf("status got %0d, expected %0d", res.status, want.status));
        end
      end
      if (req.valid && req.ready)
        pending_results.push_back(advance_run_list(req.opcode, req.task_id));
    end
    outstanding = pending_results.size();
  end

endmodule

// ----- dv/tb_round_robin_task_run_list_unit.sv -----
// Testbench top for the round-robin task run list: clock, reset, request and
// result traffic with random gaps and stalls, and the verdict.
// Depends on rrtl_pkg, the rrtl interfaces, the block and rrtl_run_list_checker.
module tb_round_robin_task_run_list_unit;
  import rrtl_pkg::*;

  localparam int NUM_TASKS    = 16;
  localparam int RANDOM_ITEMS = 550;
  localparam int PHASE_ITEMS  = 50;
  localparam int LONG_HOLD    = 80;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ROTATE,
    MIX_ANY
  } op_mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   errors, outstanding, checked;
  int   n_sent [4] = '{0, 0, 0, 0};
  logic gaps_on_tx = 1'b0;
  logic hold_rx = 1'b0;

  rrtl_req_if req_if ();
  rrtl_res_if res_if ();

  round_robin_task_run_list_unit #(
    .MAX_TASKS(NUM_TASKS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if)
  );

  rrtl_run_list_checker #(
    .NUM_TASKS(NUM_TASKS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .res(res_if),
    .errors(errors),
    .outstanding(outstanding),
    .checked(checked)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one request item, with an optional gap before it
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [TASK_W-1:0] id);
    int gap;
    gap = gaps_on_tx ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.opcode  <= op;
    req_if.task_id <= id;
    do @(posedge clk); while (!req_if.ready);
    n_sent[op]++;
  endtask

  // Stop offering until every expected result has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [OPCODE_W-1:0] pick_opcode(input op_mix_t mix);
    int roll;
    int run_pct, sleep_pct;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:   begin run_pct = 65; sleep_pct = 15; end
      MIX_DRAIN:  begin run_pct = 20; sleep_pct = 55; end
      MIX_ROTATE: begin run_pct = 20; sleep_pct = 20; end
      default:    begin run_pct = 32; sleep_pct = 32; end
    endcase
    if (roll < 4) return OP_UNUSED;
    if (roll < 4 + run_pct) return OP_RUN;
    if (roll < 4 + run_pct + sleep_pct) return OP_SLEEP;
    return OP_SLICE;
  endfunction

  // Result side: random stalls, calm stretches, one long hold-off on request
  initial begin : result_sink
    int   gap;
    int   served;
    logic rx_gappy;
    served   = 0;
    rx_gappy = 1'b0;
    res_if.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_rx = 1'b0;
      end
      if (served % 40 == 0) rx_gappy = 1'($urandom_range(0, 1));
      gap = rx_gappy ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      served++;
    end
  end

  // Request side and verdict
  initial begin : request_source
    op_mix_t mix;
    req_if.valid   <= 1'b0;
    req_if.opcode  <= OP_RUN;
    req_if.task_id <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corner cases from the reset list of task 0 alone
    gaps_on_tx = 1'b1;
    send_request(OP_SLICE, 4'd9);      // one running task: no change
    send_request(OP_SLEEP, 4'd0);      // last running task: refused
    send_request(OP_RUN, 4'd0);        // already running
    send_request(OP_UNUSED, 4'd15);    // unused opcode
    send_request(OP_SLEEP, 4'd5);      // idle task only marked asleep
    send_request(OP_SLEEP, 4'd5);      // already sleeping
    send_request(OP_RUN, 4'd5);        // wake
    send_request(OP_RUN, 4'd15);
    send_request(OP_RUN, 4'd3);
    gaps_on_tx = 1'b0;
    repeat (4) send_request(OP_SLICE, 4'd0);   // full turn, tail wraps to head
    send_request(OP_SLEEP, 4'd0);      // head and current
    send_request(OP_SLEEP, 4'd3);      // tail, not current
    send_request(OP_RUN, 4'd10);
    send_request(OP_SLICE, 4'd15);
    send_request(OP_SLEEP, 4'd15);     // middle and current
    send_request(OP_RUN, 4'd12);
    send_request(OP_SLEEP, 4'd10);     // middle and current, successor is the tail
    send_request(OP_SLEEP, 4'd12);     // tail and current
    send_request(OP_RUN, 4'd0);
    send_request(OP_SLICE, 4'd15);
    wait_drained();

    // Random phases, each biased toward filling, draining or rotating the list, or unbiased
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        mix        = op_mix_t'($urandom_range(0, 3));
        gaps_on_tx = 1'($urandom_range(0, 1));
      end
      if (i == 150) hold_rx = 1'b1;
      if (i == 300 || i == 420) wait_drained();
      send_request(pick_opcode(mix), TASK_W'($urandom_range(0, NUM_TASKS - 1)));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests: %0d run, %0d sleep, %0d slice expiry, %0d unused opcode",
             n_sent[0] + n_sent[1] + n_sent[2] + n_sent[3],
             n_sent[OP_RUN], n_sent[OP_SLEEP], n_sent[OP_SLICE], n_sent[OP_UNUSED]);
    $display("Checked %0d results with random stalls, a long result hold-off and drain pauses",
             checked);
    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, outstanding);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/rrtl_pkg.sv
design/rrtl_if.sv
design/rrtl_ctrl.sv
design/rrtl_dp.sv
design/round_robin_task_run_list_unit.sv
dv/rrtl_run_list_checker.sv
dv/tb_round_robin_task_run_list_unit.sv
